// ----- hdl/bbsp_pkg.sv -----
// Shared types, constants and the elaboration-time log helper for the
// Bethe-Bloch stopping power pipeline. No dependencies.
package bbsp_pkg;

   localparam int OUT_FRAC_BITS_DEF = 16;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   localparam int P_W  = 27;
   localparam int M_W  = 22;
   localparam int P2_W = 54;
   localparam int M2_W = 44;
   localparam int E2_W = 55;
   localparam int DQ_W = 49;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SAT   = 2'd1;
   localparam logic [1:0] ST_CLAMP = 2'd2;

   localparam logic [27:0] LN2_Q28  = 28'd186065280;
   localparam logic [31:0] LNC_Q28  = 32'd3888875722;
   localparam logic [25:0] KZA_Q28  = 26'd37141722;
   localparam logic [9:0]  TWO_ME   = 10'd1022;
   localparam logic [22:0] ME2_Q4   = 23'd4177936;
   localparam logic [28:0] Q28_ONE  = 29'd268435456;

   // log2 in Q28 by repeated squaring; used on constants only
   function automatic logic [33:0] log2_q28_f(input logic [63:0] x);
      logic [5:0]  n;
      logic [63:0] m;
      logic [33:0] res;
      n = '0;
      for (int b = 0; b < 64; b++) begin
         if (x[b]) n = 6'(b);
      end
      if (n >= 6'd30) m = x >> (n - 6'd30);
      else m = x << (6'd30 - n);
      res = {n, 28'd0};
      for (int i = 27; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m[31]) begin
            m = m >> 1;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   localparam logic [33:0] LG1022_Q28 = log2_q28_f(64'd1022);

   typedef struct packed {
      logic             zero;
      logic [P_W-1:0]   p;
      logic [P2_W-1:0]  p2;
      logic [E2_W-1:0]  e2;
      logic [M2_W-1:0]  m2;
   } sqrt_sb_type;

   typedef struct packed {
      logic [P2_W-1:0]  p2;
      logic [E2_W-1:0]  e2;
   } logp_sb_type;

   typedef struct packed {
      logic             zero;
      logic [36:0]      lnp;
      logic [P2_W-1:0]  p2;
      logic [E2_W-1:0]  e2;
   } div1_sb_type;

endpackage

// ----- hdl/bbsp_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on nothing; instantiated by the top level.
module bbsp_isqrt #(
   parameter int RW  = 32,
   parameter int SBW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_x,
   input  logic [SBW-1:0]  in_sb,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SBW-1:0]  out_sb
);
   localparam int XW = 2 * RW;

   logic           v_ff    [0:RW];
   logic [RW+1:0]  rem_ff  [0:RW];
   logic [RW-1:0]  root_ff [0:RW];
   logic [XW-1:0]  x_ff    [0:RW];
   logic [SBW-1:0] sb_ff   [0:RW];

   logic [RW+3:0]  shifted [0:RW-1];
   logic [RW+3:0]  trial   [0:RW-1];
   logic           ge      [0:RW-1];
   logic [RW+1:0]  rem_in  [0:RW-1];
   logic [RW-1:0]  root_in [0:RW-1];

   always_comb begin
      for (int j = 0; j < RW; j++) begin
         shifted[j] = {rem_ff[j], x_ff[j][XW-1:XW-2]};
         trial[j]   = (RW+4)'({root_ff[j], 2'b01});
         ge[j]      = shifted[j] >= trial[j];
         rem_in[j]  = ge[j] ? (RW+2)'(shifted[j] - trial[j]) : (RW+2)'(shifted[j]);
         root_in[j] = {root_ff[j][RW-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= RW; j++) v_ff[j] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int j = 0; j < RW; j++) v_ff[j+1] <= v_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         x_ff[0]    <= in_x;
         sb_ff[0]   <= in_sb;
         for (int j = 0; j < RW; j++) begin
            rem_ff[j+1]  <= rem_in[j];
            root_ff[j+1] <= root_in[j];
            x_ff[j+1]    <= x_ff[j] << 2;
            sb_ff[j+1]   <= sb_ff[j];
         end
      end
   end

   assign out_valid = v_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_sb    = sb_ff[RW];

endmodule

// ----- hdl/bbsp_log2.sv -----
// Pipelined log2 in Q28: leading-one stage, normalize stage, then one
// squaring stage per fraction bit. Depends on nothing.
module bbsp_log2 #(
   parameter int W   = 49,
   parameter int SBW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [W-1:0]          in_x,
   input  logic [SBW-1:0]        in_sb,
   output logic                  out_valid,
   output logic [$clog2(W)+27:0] out_log,
   output logic [SBW-1:0]        out_sb
);
   localparam int NB = $clog2(W);
   localparam int FB = 28;

   logic           va_ff, vb_ff;
   logic [W-1:0]   xa_ff, xb_ff;
   logic [SBW-1:0] sba_ff, sbb_ff;
   logic [NB-1:0]  nb_ff;

   logic           v_ff  [0:FB];
   logic [30:0]    m_ff  [0:FB];
   logic [FB-1:0]  fr_ff [0:FB];
   logic [NB-1:0]  n_ff  [0:FB];
   logic [SBW-1:0] sb_ff [0:FB];

   logic [NB-1:0]  n_in;
   logic [NB-1:0]  lsh;
   logic [W-1:0]   xs;
   logic [W+30:0]  wide;
   logic [30:0]    m0_in;
   logic [61:0]    sq    [0:FB-1];
   logic [31:0]    sqh   [0:FB-1];
   logic [30:0]    m_in  [0:FB-1];

   // leading one
   always_comb begin
      n_in = '0;
      for (int b = 0; b < W; b++) begin
         if (xa_ff[b]) n_in = NB'(b);
      end
   end

   assign lsh   = NB'(W - 1) - nb_ff;
   assign xs    = xb_ff << lsh;
   assign wide  = {xs, 31'd0};
   assign m0_in = wide[W+30 -: 31];

   always_comb begin
      for (int k = 0; k < FB; k++) begin
         sq[k]   = 62'(m_ff[k]) * 62'(m_ff[k]);
         sqh[k]  = sq[k][61:30];
         m_in[k] = sqh[k][31] ? sqh[k][31:1] : sqh[k][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         for (int k = 0; k <= FB; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         va_ff   <= in_valid;
         vb_ff   <= va_ff;
         v_ff[0] <= vb_ff;
         for (int k = 0; k < FB; k++) v_ff[k+1] <= v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xa_ff    <= in_x;
         sba_ff   <= in_sb;
         xb_ff    <= xa_ff;
         nb_ff    <= n_in;
         sbb_ff   <= sba_ff;
         m_ff[0]  <= m0_in;
         fr_ff[0] <= '0;
         n_ff[0]  <= nb_ff;
         sb_ff[0] <= sbb_ff;
         for (int k = 0; k < FB; k++) begin
            m_ff[k+1]  <= m_in[k];
            fr_ff[k+1] <= {fr_ff[k][FB-2:0], sqh[k][31]};
            n_ff[k+1]  <= n_ff[k];
            sb_ff[k+1] <= sb_ff[k];
         end
      end
   end

   assign out_valid = v_ff[FB];
   assign out_log   = {n_ff[FB], fr_ff[FB]};
   assign out_sb    = sb_ff[FB];

endmodule

// ----- hdl/bbsp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Expects the quotient to fit in QW bits. Depends on nothing.
module bbsp_div #(
   parameter int NW  = 63,
   parameter int DW  = 35,
   parameter int QW  = 29,
   parameter int SBW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [NW-1:0]  in_num,
   input  logic [DW-1:0]  in_den,
   input  logic [SBW-1:0] in_sb,
   output logic           out_valid,
   output logic [QW-1:0]  out_quo,
   output logic [SBW-1:0] out_sb
);
   logic           v_ff   [0:QW];
   logic [DW-1:0]  rem_ff [0:QW];
   logic [QW-1:0]  low_ff [0:QW];
   logic [QW-1:0]  q_ff   [0:QW];
   logic [DW-1:0]  den_ff [0:QW];
   logic [SBW-1:0] sb_ff  [0:QW];

   logic [DW:0]    trial  [0:QW-1];
   logic           ge     [0:QW-1];
   logic [DW-1:0]  rem_in [0:QW-1];

   always_comb begin
      for (int j = 0; j < QW; j++) begin
         trial[j]  = {rem_ff[j], low_ff[j][QW-1]};
         ge[j]     = trial[j] >= {1'b0, den_ff[j]};
         rem_in[j] = ge[j] ? DW'(trial[j] - {1'b0, den_ff[j]}) : DW'(trial[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) v_ff[j] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int j = 0; j < QW; j++) v_ff[j+1] <= v_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DW'(in_num >> QW);
         low_ff[0] <= in_num[QW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= in_den;
         sb_ff[0]  <= in_sb;
         for (int j = 0; j < QW; j++) begin
            rem_ff[j+1] <= rem_in[j];
            low_ff[j+1] <= low_ff[j] << 1;
            q_ff[j+1]   <= {q_ff[j][QW-2:0], ge[j]};
            den_ff[j+1] <= den_ff[j];
            sb_ff[j+1]  <= sb_ff[j];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_quo   = q_ff[QW];
   assign out_sb    = sb_ff[QW];

endmodule

// ----- hdl/bethe_bloch_stopping_power.sv -----
// Top level of the liquid-argon Bethe-Bloch stopping power pipeline.
// Depends on bbsp_pkg, bbsp_isqrt, bbsp_log2 and bbsp_div.
//
//  channel | dir | tdata (low bit up)                     | tuser
//  req_    | in  | momentum_kev[26:0], mass_kev[48:27]     | -
//  rsp_    | out | stopping_power[31:0]                   | status[1:0]
//
// One transfer enters per clock while req_tready is high. A request passes
// through two front registers, the square root (33 register stages),
// the two parallel log2 units (31), two scaling registers, the beta^2 divider
// (30), four bracket and scaling registers, the output divider (33) and the
// output register. All stages advance together while the skid slot is empty;
// a full skid slot freezes the pipeline and drops req_tready.
// Reset (synchronous, active high) clears only the valid bits.
module bethe_bloch_stopping_power #(
   parameter int OUT_FRAC_BITS = bbsp_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bbsp_pkg::REQ_DATA_W-1:0] req_tdata,   // momentum_kev, mass_kev
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bbsp_pkg::RSP_DATA_W-1:0] rsp_tdata,   // stopping_power
   output logic [bbsp_pkg::RSP_USER_W-1:0] rsp_tuser    // status
);
   import bbsp_pkg::*;

   localparam int S_SH = 29 - OUT_FRAC_BITS;   // final scale shift
   localparam int NW2  = 89 - S_SH;             // scaled numerator width

   // global advance: frozen only while the skid slot holds a result
   logic en;

   // front: capture, square, sum
   logic             v0_ff, v1_ff;
   logic [P_W-1:0]   p0_ff, p1_ff;
   logic [M_W-1:0]   m0_ff;
   logic [P2_W-1:0]  p2_1_ff;
   logic [M2_W-1:0]  m2_1_ff;
   logic [E2_W-1:0]  e2_1;
   sqrt_sb_type      sq_sb_in, sq_sb_out;

   logic             sq_valid;
   logic [31:0]      eq4;
   logic [DQ_W-1:0]  dq4_in;
   logic [DQ_W-1:0]  p_ext;

   logp_sb_type      lp_sb_in, lp_sb_out;
   logic             lp_valid, ld_valid, ld_zero;
   logic [32:0]      lgp;
   logic [33:0]      lgd;

   // stage X1: log2 of Tmax and the e2 normalizing shift
   logic             x1_v_ff, x1_zero_ff;
   logic [35:0]      x1_l2_ff;
   logic [4:0]       x1_k_ff;
   logic [P2_W-1:0]  x1_p2_ff;
   logic [E2_W-1:0]  x1_e2_ff;
   logic [35:0]      l2_in;
   logic [4:0]       k_in;
   logic [5:0]       top_in;

   // stage X2: ln scaling product and shifted divide operands
   logic             x2_v_ff, x2_zero_ff, x2_neg_ff;
   logic [62:0]      x2_prod_ff;
   logic [34:0]      x2_a2_ff, x2_b2d_ff;
   logic [P2_W-1:0]  x2_p2_ff;
   logic [E2_W-1:0]  x2_e2_ff;
   logic [34:0]      l2_mag;
   logic [34:0]      lnq;
   logic [36:0]      lnp_in;
   div1_sb_type      d1_sb_in, d1_sb_out;

   logic             d1_valid;
   logic [28:0]      b2;

   // stages Y1..Y4: bracket, KZA scaling, A*e2, scale
   logic             y1_v_ff, y2_v_ff, y3_v_ff, y4_v_ff;
   logic [36:0]      y1_t2_ff;
   logic [1:0]       y1_st_ff, y2_st_ff, y3_st_ff, y4_st_ff;
   logic [P2_W-1:0]  y1_p2_ff, y2_p2_ff, y3_p2_ff, y4_p2_ff;
   logic [E2_W-1:0]  y1_e2_ff, y2_e2_ff;
   logic [33:0]      y2_a_ff;
   logic [61:0]      y3_pl_ff;
   logic [60:0]      y3_ph_ff;
   logic [NW2-1:0]   y4_nsh_ff;
   logic [36:0]      t2_in;
   logic [61:0]      pa_in;
   logic [88:0]      n_in;

   logic             sat_in;
   logic [1:0]       st_in;
   logic [NW2-1:0]   num2_in;
   logic [P2_W-1:0]  den2_in;

   logic             d2_valid;
   logic [31:0]      quo;
   logic [1:0]       d2_st;
   logic [31:0]      fin_data;

   // output register and skid slot
   logic             out_valid_ff, skid_valid_ff;
   logic [31:0]      out_data_ff, skid_data_ff;
   logic [1:0]       out_st_ff, skid_st_ff;
   logic             out_free;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // ---------------- front ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff   <= req_tdata[P_W-1:0];
         m0_ff   <= req_tdata[P_W+M_W-1:P_W];
         p1_ff   <= p0_ff;
         p2_1_ff <= P2_W'(p0_ff) * P2_W'(p0_ff);
         m2_1_ff <= M2_W'(m0_ff) * M2_W'(m0_ff);
      end
   end

   assign e2_1 = E2_W'(p2_1_ff) + E2_W'(m2_1_ff);

   always_comb begin
      sq_sb_in.zero = (p1_ff == '0);
      sq_sb_in.p    = p1_ff;
      sq_sb_in.p2   = p2_1_ff;
      sq_sb_in.e2   = e2_1;
      sq_sb_in.m2   = m2_1_ff;
   end

   // E with four fraction bits
   bbsp_isqrt #(
      .RW  (32),
      .SBW ($bits(sqrt_sb_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_x      ({1'b0, e2_1, 8'd0}),
      .in_sb     (sq_sb_in),
      .out_valid (sq_valid),
      .out_root  (eq4),
      .out_sb    (sq_sb_out)
   );

   // Tmax denominator in Q4
   assign dq4_in = (DQ_W'(sq_sb_out.m2) << 4) + DQ_W'(TWO_ME) * DQ_W'(eq4) + DQ_W'(ME2_Q4);
   assign p_ext  = DQ_W'(sq_sb_out.p);

   always_comb begin
      lp_sb_in.p2 = sq_sb_out.p2;
      lp_sb_in.e2 = sq_sb_out.e2;
   end

   bbsp_log2 #(
      .W   (P_W),
      .SBW ($bits(logp_sb_type))
   ) u_log_p (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_x      (p_ext[P_W-1:0]),
      .in_sb     (lp_sb_in),
      .out_valid (lp_valid),
      .out_log   (lgp),
      .out_sb    (lp_sb_out)
   );

   bbsp_log2 #(
      .W   (DQ_W),
      .SBW (1)
   ) u_log_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_x      (dq4_in),
      .in_sb     (sq_sb_out.zero),
      .out_valid (ld_valid),
      .out_log   (lgd),
      .out_sb    (ld_zero)
   );

   // ---------------- X1 ----------------
   // log2 Tmax = lg(1022) + 2 lg(p) - lg(Dq4) + 4
   assign l2_in = 36'(LG1022_Q28) + (36'(lgp) << 1) - 36'(lgd) + (36'(Q28_ONE) << 2);

   always_comb begin
      top_in = '0;
      for (int b = 0; b < E2_W; b++) begin
         if (lp_sb_out.e2[b]) top_in = 6'(b);
      end
      k_in = (top_in >= 6'd35) ? 5'(top_in - 6'd34) : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_v_ff <= 1'b0;
         x2_v_ff <= 1'b0;
      end else if (en) begin
         x1_v_ff <= lp_valid && ld_valid;
         x2_v_ff <= x1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_l2_ff   <= l2_in;
         x1_k_ff    <= k_in;
         x1_p2_ff   <= lp_sb_out.p2;
         x1_e2_ff   <= lp_sb_out.e2;
         x1_zero_ff <= ld_zero;
      end
   end

   // ---------------- X2 ----------------
   assign l2_mag = x1_l2_ff[35] ? 35'(-x1_l2_ff) : x1_l2_ff[34:0];

   always_ff @(posedge clock) begin
      if (en) begin
         x2_neg_ff  <= x1_l2_ff[35];
         x2_prod_ff <= 63'(l2_mag) * 63'(LN2_Q28);
         x2_a2_ff   <= 35'(x1_p2_ff >> x1_k_ff);
         x2_b2d_ff  <= 35'(x1_e2_ff >> x1_k_ff);
         x2_p2_ff   <= x1_p2_ff;
         x2_e2_ff   <= x1_e2_ff;
         x2_zero_ff <= x1_zero_ff;
      end
   end

   // ln Tmax + ln C, truncated toward zero before the offset
   assign lnq    = x2_prod_ff[62:28];
   assign lnp_in = (x2_neg_ff ? 37'(-37'(lnq)) : 37'(lnq)) + 37'(LNC_Q28);

   always_comb begin
      d1_sb_in.zero = x2_zero_ff;
      d1_sb_in.lnp  = lnp_in;
      d1_sb_in.p2   = x2_p2_ff;
      d1_sb_in.e2   = x2_e2_ff;
   end

   // beta^2 in Q28
   bbsp_div #(
      .NW  (63),
      .DW  (35),
      .QW  (29),
      .SBW ($bits(div1_sb_type))
   ) u_div_beta (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x2_v_ff),
      .in_num    ({x2_a2_ff, 28'd0}),
      .in_den    (x2_b2d_ff),
      .in_sb     (d1_sb_in),
      .out_valid (d1_valid),
      .out_quo   (b2),
      .out_sb    (d1_sb_out)
   );

   // ---------------- Y1..Y4 ----------------
   assign t2_in = d1_sb_out.lnp - 37'({b2, 1'b0}) + 37'(Q28_ONE);
   assign pa_in = 62'(y1_t2_ff[35:0]) * 62'(KZA_Q28);
   assign n_in  = 89'(y3_pl_ff) + (89'(y3_ph_ff) << 28);

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_v_ff <= 1'b0;
         y2_v_ff <= 1'b0;
         y3_v_ff <= 1'b0;
         y4_v_ff <= 1'b0;
      end else if (en) begin
         y1_v_ff <= d1_valid;
         y2_v_ff <= y1_v_ff;
         y3_v_ff <= y2_v_ff;
         y4_v_ff <= y3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y1_t2_ff  <= t2_in;
         y1_st_ff  <= d1_sb_out.zero ? ST_SAT : (t2_in[36] ? ST_CLAMP : ST_OK);
         y1_p2_ff  <= d1_sb_out.p2;
         y1_e2_ff  <= d1_sb_out.e2;
         y2_a_ff   <= pa_in[61:28];
         y2_st_ff  <= y1_st_ff;
         y2_p2_ff  <= y1_p2_ff;
         y2_e2_ff  <= y1_e2_ff;
         y3_pl_ff  <= 62'(y2_a_ff) * 62'(y2_e2_ff[27:0]);
         y3_ph_ff  <= 61'(y2_a_ff) * 61'(y2_e2_ff[54:28]);
         y3_st_ff  <= y2_st_ff;
         y3_p2_ff  <= y2_p2_ff;
         y4_nsh_ff <= NW2'(n_in >> S_SH);
         y4_st_ff  <= y3_st_ff;
         y4_p2_ff  <= y3_p2_ff;
      end
   end

   // saturate when the quotient would need more than 32 bits
   assign sat_in  = (y4_nsh_ff >> 32) >= NW2'(y4_p2_ff);
   assign st_in   = (y4_st_ff == ST_OK && sat_in) ? ST_SAT : y4_st_ff;
   assign num2_in = (st_in == ST_OK) ? y4_nsh_ff : '0;
   assign den2_in = (st_in == ST_OK) ? y4_p2_ff : P2_W'(1);

   bbsp_div #(
      .NW  (NW2),
      .DW  (P2_W),
      .QW  (32),
      .SBW (2)
   ) u_div_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (y4_v_ff),
      .in_num    (num2_in),
      .in_den    (den2_in),
      .in_sb     (st_in),
      .out_valid (d2_valid),
      .out_quo   (quo),
      .out_sb    (d2_st)
   );

   always_comb begin
      case (d2_st)
         ST_OK:    fin_data = quo;
         ST_SAT:   fin_data = '1;
         default:  fin_data = '0;
      endcase
   end

   // ---------------- output register and skid ----------------
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // drain the parked result first
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (d2_valid) begin
         if (out_free) out_valid_ff <= 1'b1;
         else skid_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && out_free) begin
         out_data_ff <= skid_data_ff;
         out_st_ff   <= skid_st_ff;
      end else if (!skid_valid_ff && d2_valid && out_free) begin
         out_data_ff <= fin_data;
         out_st_ff   <= d2_st;
      end
      if (!skid_valid_ff && d2_valid && !out_free) begin
         skid_data_ff <= fin_data;
         skid_st_ff   <= d2_st;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_st_ff;

   // ---------------- checks ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output register empty");

   a_clamp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_CLAMP) |-> (rsp_tdata == '0))
      else $error("clamped result is not zero");

   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_SAT) |-> (rsp_tdata == '1))
      else $error("saturated result is not all ones");

endmodule

// ----- tb/sv/tb_bethe_bloch_stopping_power.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Bethe-Bloch stopping power pipeline.
// Depends on bbsp_pkg and bethe_bloch_stopping_power; holds its own fixed-point predictor.
module tb_bethe_bloch_stopping_power;
   import bbsp_pkg::*;

   localparam int FRAC    = OUT_FRAC_BITS_DEF;
   localparam int SHIFT   = 29 - FRAC;
   localparam int N_RAND  = 800;
   localparam int WD_MAX  = 5000;    // idle cycles before the watchdog fires
   localparam int DRAIN   = 200;     // pipeline is 136 deep

   // fixed-point constants of the argon medium, Q28
   localparam longint unsigned LN2_FX = 64'd186065280;
   localparam longint          LNC_FX = 64'd3888875722;
   localparam longint unsigned KZA_FX = 64'd37141722;
   localparam longint unsigned ONE_FX = 64'd1 << 28;

   typedef struct packed {
      logic [31:0] dedx;
      logic [1:0]  status;
   } dedx_type;

   typedef struct {
      logic [P_W-1:0] p;
      logic [M_W-1:0] m;
      bit             typed;    // expected value typed into the row
      dedx_type       want;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // momentum_kev[26:0], mass_kev[48:27]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // stopping_power[31:0]
   logic [RSP_USER_W-1:0] rsp_tuser;        // status[1:0]

   dedx_type pending_dedx[$];
   int    n_err = 0;
   int    n_sent = 0;
   int    n_got = 0;
   int    n_sat = 0;
   int    n_clamp = 0;
   int    idle_cycles = 0;
   bit    hold_rsp = 1'b0;
   bit    pressure_done = 1'b0;

   always #5 clock = ~clock;

   bethe_bloch_stopping_power #(.OUT_FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // ---------------------------------------------------------------- predictor
   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2 in Q28: top bit index, then mantissa squared bit by bit
   function automatic longint unsigned log2_fx(longint unsigned x);
      int              top;
      longint unsigned mant;
      longint unsigned acc;
      top = 0;
      for (int k = 0; k < 64; k++) if (x[k]) top = k;
      mant = (top >= 30) ? (x >> (top - 30)) : (x << (30 - top));
      acc = longint'(top) << 28;
      for (int k = 27; k >= 0; k--) begin
         mant = (mant * mant) >> 30;
         if (mant >= (64'd1 << 31)) begin
            mant = mant >> 1;
            acc = acc + (64'd1 << k);
         end
      end
      return acc;
   endfunction

   function automatic dedx_type predict_dedx(logic [P_W-1:0] p, logic [M_W-1:0] m);
      longint unsigned p2, m2, e2, eq4, dq4, num, den, beta2, kza_t;
      longint          l2, ln_tmax, bracket2;
      logic [127:0]    prod, quot;
      dedx_type        res;
      if (p == 0) begin
         res.dedx = '1;
         res.status = ST_SAT;
         return res;
      end
      p2 = longint'(p) * longint'(p);
      m2 = longint'(m) * longint'(m);
      e2 = p2 + m2;
      eq4 = root_floor(e2 << 8);
      dq4 = (m2 << 4) + 64'd1022 * eq4 + ((64'd511 * 64'd511) << 4);
      l2 = longint'(log2_fx(64'd1022)) + 2 * longint'(log2_fx(longint'(p)))
         - longint'(log2_fx(dq4)) + 4 * longint'(ONE_FX);
      // scale log2 to ln, rounding toward zero on both signs
      if (l2 < 0) ln_tmax = -longint'((longint'(-l2) * LN2_FX) >> 28);
      else ln_tmax = longint'((longint'(l2) * LN2_FX) >> 28);
      ln_tmax = ln_tmax + LNC_FX;
      num = p2;
      den = e2;
      while (den >= (64'd1 << 35)) begin
         num = num >> 1;
         den = den >> 1;
      end
      beta2 = (num << 28) / den;
      bracket2 = ln_tmax - 2 * longint'(beta2) + longint'(ONE_FX);
      if (bracket2 < 0) begin
         res.dedx = '0;
         res.status = ST_CLAMP;
         return res;
      end
      kza_t = (KZA_FX * longint'(bracket2)) >> 28;
      prod = 128'(kza_t) * 128'(e2);
      quot = prod / 128'(p2);
      if (quot >= (128'd1 << (32 + SHIFT))) begin
         res.dedx = '1;
         res.status = ST_SAT;
      end else begin
         res.dedx = 32'(quot >> SHIFT);
         res.status = ST_OK;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- helpers
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_err++;
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(15, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // offer one transfer at the falling edge and hold it until accepted;
   // the expectation is queued when the handshake lands
   task automatic send_item(logic [P_W-1:0] p, logic [M_W-1:0] m, bit bursty,
                            bit typed, dedx_type want);
      int gap;
      gap = bursty ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {7'd0, m, p};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_dedx.push_back(typed ? want : predict_dedx(p, m));
      n_sent++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- receiver
   // drive ready at the falling edge; a long hold-off fills the pipeline
   initial begin
      int gap;
      int mode_left;
      bit steady;
      mode_left = 0;
      steady = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
            pressure_done = 1'b1;
         end
         if (mode_left == 0) begin
            steady = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 200);
         end
         mode_left--;
         gap = steady ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(negedge clock);
      end
   end

   // check every accepted result against the oldest expectation
   always @(posedge clock) begin
      dedx_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_got++;
         if (pending_dedx.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 32'd0);
         end else begin
            want = pending_dedx.pop_front();
            if (want.status == ST_SAT) n_sat++;
            if (want.status == ST_CLAMP) n_clamp++;
            if (rsp_tdata !== want.dedx)
               report_mismatch("stopping_power", rsp_tdata, want.dedx);
            if (rsp_tuser !== want.status)
               report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
         end
      end
   end

   // watchdog: count cycles without any transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_MAX) begin
         $display("watchdog: no transfer for %0d cycles", WD_MAX);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      row_type         rows[$];
      row_type         r;
      dedx_type        none;
      logic [P_W-1:0]  p;
      logic [M_W-1:0]  m;
      int              sel;
      int              bits;
      bit              bursty;
      none = '0;
      // zero momentum saturates; everything else goes through the predictor
      rows.push_back('{27'd0, 22'd105658, 1'b1, '{32'hFFFFFFFF, ST_SAT}});
      rows.push_back('{27'd0, 22'd0, 1'b1, '{32'hFFFFFFFF, ST_SAT}});
      rows.push_back('{27'd0, '1, 1'b1, '{32'hFFFFFFFF, ST_SAT}});
      rows.push_back('{27'd1, 22'd1, 1'b0, none});
      rows.push_back('{27'd1, 22'd4000000, 1'b0, none});        // deep clamp
      rows.push_back('{27'd10, 22'd938272, 1'b0, none});
      rows.push_back('{27'd1000, 22'd938272, 1'b0, none});       // near clamp edge
      rows.push_back('{27'd30000, 22'd938272, 1'b0, none});
      rows.push_back('{27'd100, 22'd511, 1'b0, none});
      rows.push_back('{27'd105000, 22'd105658, 1'b0, none});     // minimum ionizing area
      rows.push_back('{27'd300000, 22'd105658, 1'b0, none});
      rows.push_back('{27'd1000000, 22'd139570, 1'b0, none});
      rows.push_back('{27'd100000000, 22'd1, 1'b0, none});
      rows.push_back('{27'd100000000, 22'd4000000, 1'b0, none});
      rows.push_back('{27'd100000000, 22'd0, 1'b0, none});       // massless
      rows.push_back('{27'd1, 22'd0, 1'b0, none});
      rows.push_back('{'1, '1, 1'b0, none});                      // all ones
      rows.push_back('{'1, 22'd0, 1'b0, none});
      rows.push_back('{27'd5, '1, 1'b0, none});
      rows.push_back('{27'd50000, 22'd3727379, 1'b0, none});     // alpha-like mass

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         r = rows[i];
         send_item(r.p, r.m, 1'b0, r.typed, r.want);
      end

      bursty = 1'b0;
      for (int n = 0; n < N_RAND; n++) begin
         // keep offering back to back while the receiver holds off
         if (n % 64 == 0 && !hold_rsp) bursty = ($urandom_range(0, 2) == 0);
         // stall the receiver once while the sender keeps offering
         if (n == 300) begin
            hold_rsp = 1'b1;
            bursty = 1'b1;
         end
         sel = $urandom_range(0, 9);
         bits = $urandom_range(1, P_W);
         p = P_W'($urandom_range(0, (1 << bits) - 1));
         case (sel)
            0: m = M_W'($urandom());                              // full field width
            1: m = 22'd0;
            2: begin                                              // low momentum, heavy
               p = P_W'($urandom_range(1, 4000));
               m = M_W'($urandom_range(500000, 4194303));
            end
            3: begin                                              // both fields at random
               p = P_W'($urandom());
               m = M_W'($urandom());
            end
            default: begin
               case ($urandom_range(0, 5))
                  0: m = 22'd511;
                  1: m = 22'd105658;
                  2: m = 22'd139570;
                  3: m = 22'd493677;
                  4: m = 22'd938272;
                  default: m = M_W'($urandom_range(1, 4000000));
               endcase
            end
         endcase
         if (sel == 0 || sel == 1) p = P_W'($urandom_range(0, 100000000));
         send_item(p, m, bursty, 1'b0, none);
      end
      req_tvalid = 1'b0;

      wait (pending_dedx.size() == 0);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d transfers in, %0d results out (%0d saturated, %0d clamped)",
               n_sent, n_got, n_sat, n_clamp);
      $display("receiver hold-off exercised: %0d", pressure_done);
      if (n_err == 0 && pending_dedx.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
